[rtl/resource_barrier_tracker_defines.svh]
// Assertion macros shared by the resource barrier tracker checker.
// Depends on nothing; included by files that assert.
`ifndef RESOURCE_BARRIER_TRACKER_DEFINES_SVH
`define RESOURCE_BARRIER_TRACKER_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define RBT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Implication checked on every clock edge, including reset.
`define RBT_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`endif

[rtl/rbt_pkg.sv]
// Package for the resource barrier tracker: item types and status codes.
// Depends on nothing.
`timescale 1ns / 1ps
package rbt_pkg;
    typedef struct packed {
        logic        mode;
        logic [31:0] resource_key;
        logic        is_texture;
        logic [3:0]  initial_layout;
        logic        view_valid;
        logic [2:0]  view_kind;
        logic        is_write;
        logic        is_compute;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] barrier_key;
        logic        texture_barrier;
        logic [2:0]  stage_before;
        logic [2:0]  stage_after;
        logic [2:0]  access_before;
        logic [2:0]  access_after;
        logic [3:0]  layout_before;
        logic [3:0]  layout_after;
        logic        last;
    } out_item_t;

    // Per-entry payload kept in the entry memory.
    typedef struct packed {
        logic [31:0] key;
        logic        is_texture;
        logic [2:0]  stage;
        logic [2:0]  access;
        logic [3:0]  layout;
        logic [3:0]  initial_layout;
        logic        written;
    } entry_t;

    localparam logic [2:0] ST_BARRIER  = 3'd0;
    localparam logic [2:0] ST_NONE     = 3'd1;
    localparam logic [2:0] ST_BAD_VIEW = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_UNDEF    = 3'd4;
    localparam logic [2:0] ST_FRAME    = 3'd5;

    localparam logic [2:0] ACC_UAV = 3'd3;
    localparam logic [2:0] ACC_NONE = 3'd0;
endpackage

[rtl/rbt_match.sv]
// Key lookup for the resource barrier tracker: keys and valid bits per slot,
// first match and first free slot. Depends on nothing.
`timescale 1ns / 1ps
module rbt_match #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [31:0]   key,
    input  logic          ins_en,
    input  logic [AW-1:0] ins_slot,
    input  logic          clear,
    output logic          hit,
    output logic [AW-1:0] hit_slot,
    output logic          free,
    output logic [AW-1:0] free_slot,
    output logic [DEPTH-1:0] valid
);
    logic [DEPTH-1:0] valid_reg;
    logic [31:0]      key_reg [DEPTH];

    assign valid = valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (clear)
        begin
            valid_reg <= '0;
        end
        else if (ins_en)
        begin
            valid_reg[ins_slot] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ins_en)
        begin
            key_reg[ins_slot] <= key;
        end
    end

    // Priority encoders, lowest slot wins.
    always_comb
    begin
        hit       = 1'b0;
        hit_slot  = '0;
        free      = 1'b0;
        free_slot = '0;
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && key_reg[i] == key)
            begin
                hit      = 1'b1;
                hit_slot = AW'(i);
            end
            if (!valid_reg[i])
            begin
                free      = 1'b1;
                free_slot = AW'(i);
            end
        end
    end
endmodule

[rtl/rbt_entry_mem.sv]
// Entry memory of the resource barrier tracker: one write and one
// registered read port. Depends on rbt_pkg.
`timescale 1ns / 1ps
module rbt_entry_mem #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic            clk,
    input  logic            we,
    input  logic [AW-1:0]   waddr,
    input  rbt_pkg::entry_t wdata,
    input  logic [AW-1:0]   raddr,
    output rbt_pkg::entry_t rdata
);
    rbt_pkg::entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[rtl/resource_barrier_tracker.sv]
// Resource barrier tracker: an access item is looked up and its entry read in the
// acceptance cycle; the entry is written back and the result registered in the next,
// and the next item is accepted the cycle after the result is taken; a bad view or
// full table registers its result at acceptance without an entry read.
// End of frame walks TABLE_DEPTH slots, one a cycle while the output is free; a valid
// texture slot off its initial layout gives a restore item, and the frame-end item comes last.
// Reset is asynchronous, active low, and empties the table at once through the valid bits.
`timescale 1ns / 1ps
module resource_barrier_tracker #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  rbt_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output rbt_pkg::out_item_t out_data
);
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    // Sequencer states.
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_READ  = 3'd1;  // entry read in flight
    localparam logic [2:0] S_FLUSH = 3'd2;  // walking the table
    localparam logic [2:0] S_FEND  = 3'd3;  // frame-end item issued and table cleared once the output is free
    localparam logic [2:0] S_OUT   = 3'd4;  // unused; a result waits for the consumer in S_IDLE

    logic [2:0]         state_reg, state_next;
    rbt_pkg::in_item_t  item_reg;
    logic               insert_reg;
    logic [AW-1:0]      slot_reg;
    logic [AW:0]        scan_reg;
    logic [AW-1:0]      scan_slot_reg;
    logic               out_valid_reg;
    rbt_pkg::out_item_t out_reg;

    logic          hit, free;
    logic [AW-1:0] hit_slot, free_slot;
    logic [TABLE_DEPTH-1:0] valid;
    logic          ins_en, clear;
    logic          mem_we;
    logic [AW-1:0] raddr;
    rbt_pkg::entry_t rdata, wdata;

    // Target stage, access and layout from the view kind.
    logic [2:0] sa, aa;
    logic [3:0] la;
    logic       ok;

    always_comb
    begin
        sa = in_data.is_compute ? 3'd2 : 3'd1;
        aa = 3'd0;
        la = 4'd0;
        ok = 1'b1;
        if (!in_data.is_texture)
        begin
            case (in_data.view_kind)
                3'd0:    aa = 3'd1;
                3'd1:    aa = 3'd2;
                3'd2:    aa = 3'd3;
                default: ok = 1'b0;
            endcase
        end
        else
        begin
            case (in_data.view_kind)
                3'd1:    begin aa = 3'd2; la = 4'd1; end
                3'd2:    begin aa = 3'd3; la = 4'd2; end
                3'd3:    begin sa = 3'd3; aa = 3'd4; la = 4'd3; end
                3'd4:
                begin
                    sa = 3'd4;
                    aa = in_data.is_write ? 3'd5 : 3'd6;
                    la = in_data.is_write ? 4'd4 : 4'd5;
                end
                default: ok = 1'b0;
            endcase
        end
    end

    // Results formed without an entry read: bad view or table full, and frame end.
    rbt_pkg::out_item_t early_res, frame_res;
    always_comb
    begin
        early_res                 = '0;
        early_res.status          = !ok ? rbt_pkg::ST_BAD_VIEW : rbt_pkg::ST_FULL;
        early_res.barrier_key     = in_data.resource_key;
        early_res.texture_barrier = in_data.is_texture;
        early_res.last            = 1'b1;
        frame_res                 = '0;
        frame_res.status          = rbt_pkg::ST_FRAME;
        frame_res.last            = 1'b1;
    end

    // Stored target fields of the item in flight.
    logic [2:0] sa_reg, aa_reg;
    logic [3:0] la_reg;

    wire accept = in_valid && in_ready;
    wire access = accept && !in_data.mode && in_data.view_valid && ok;
    wire do_ins = access && !hit && free;

    assign in_ready  = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign ins_en = do_ins;
    assign clear  = (state_reg == S_FEND) && !out_valid_reg;

    rbt_match #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_match (
        .clk(clk), .rst_n(rst_n), .key(in_data.resource_key),
        .ins_en(ins_en), .ins_slot(free_slot), .clear(clear),
        .hit(hit), .hit_slot(hit_slot), .free(free), .free_slot(free_slot),
        .valid(valid)
    );

    // Read-modify-write: the entry update is written back when the result
    // forms; insertions write their fresh entry then as well, so the read of
    // a just-inserted slot is replaced by the insertion values.
    rbt_pkg::entry_t cur;
    always_comb
    begin
        cur = rdata;
        if (insert_reg)
        begin
            cur.key            = item_reg.resource_key;
            cur.is_texture     = item_reg.is_texture;
            cur.stage          = 3'd0;
            cur.access         = 3'd0;
            cur.layout         = item_reg.initial_layout;
            cur.initial_layout = item_reg.initial_layout;
            cur.written        = 1'b0;
        end
        wdata        = cur;
        wdata.stage  = sa_reg;
        wdata.access = aa_reg;
        wdata.written = item_reg.is_write;
        if (item_reg.is_texture)
        begin
            wdata.layout = la_reg;
        end
    end
    assign mem_we = (state_reg == S_READ);

    rbt_entry_mem #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_mem (
        .clk(clk), .we(mem_we), .waddr(slot_reg), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    logic [3:0] lb, la_eff;
    logic       need;
    always_comb
    begin
        lb     = item_reg.is_texture ? cur.layout : 4'd0;
        la_eff = item_reg.is_texture ? la_reg : 4'd0;
        need   = (lb != la_eff) ||
                 ((cur.access == rbt_pkg::ACC_UAV || aa_reg == rbt_pkg::ACC_UAV) &&
                  (cur.written || item_reg.is_write) &&
                  cur.access != rbt_pkg::ACC_NONE && aa_reg != rbt_pkg::ACC_NONE);
    end

    wire restore = valid[scan_slot_reg] && rdata.is_texture &&
                   (rdata.layout != rdata.initial_layout);
    wire out_free = !out_valid_reg || out_ready;

    // An end-of-frame item starts the walk at slot 0. While a restore waits
    // for the consumer, the slot under test is read again so that its data
    // stays in the read register.
    always_comb
    begin
        case (state_reg)
            S_IDLE:  raddr = in_data.mode ? '0 : hit_slot;
            S_FLUSH: raddr = out_free ? scan_reg[AW-1:0] : scan_slot_reg;
            default: raddr = scan_slot_reg;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (in_data.mode)
                    begin
                        state_next = S_FLUSH;
                    end
                    else if (in_data.view_valid && ok && (hit || free))
                    begin
                        state_next = S_READ;
                    end
                end
            end
            S_READ:  state_next = S_IDLE;
            S_FLUSH:
            begin
                // One read issued per cycle while the output can take the
                // previous restore.
                if (out_free && scan_reg == (AW+1)'(TABLE_DEPTH))
                begin
                    state_next = S_FEND;
                end
            end
            S_FEND:  if (!out_valid_reg) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            scan_reg      <= '0;
            scan_slot_reg <= '0;
            insert_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    scan_reg <= '0;
                    if (accept)
                    begin
                        insert_reg <= do_ins;
                        if (in_data.mode)
                        begin
                            scan_reg <= (AW+1)'(1);
                            scan_slot_reg <= '0;
                        end
                        else if (in_data.view_valid && (!ok || (!hit && !free)))
                        begin
                            out_valid_reg <= 1'b1;
                        end
                    end
                end
                S_READ: out_valid_reg <= 1'b1;
                S_FLUSH:
                begin
                    if (out_free)
                    begin
                        // Data for scan_slot_reg is valid now.
                        if (restore)
                        begin
                            out_valid_reg <= 1'b1;
                        end
                        scan_slot_reg <= scan_reg[AW-1:0];
                        if (scan_reg != (AW+1)'(TABLE_DEPTH))
                        begin
                            scan_reg <= scan_reg + 1'b1;
                        end
                    end
                end
                S_FEND:
                begin
                    if (!out_valid_reg)
                    begin
                        out_valid_reg <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Item and result registers: the flush reads slot scan_reg-1 data
    // in S_FLUSH; in S_FEND the final slot's data was consumed already.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    item_reg <= in_data;
                    sa_reg   <= sa;
                    aa_reg   <= aa;
                    la_reg   <= la;
                    slot_reg <= hit ? hit_slot : free_slot;
                    out_reg  <= early_res;
                end
            end
            S_READ:
            begin
                out_reg.status <= need ? rbt_pkg::ST_BARRIER : rbt_pkg::ST_NONE;
                out_reg.barrier_key     <= item_reg.resource_key;
                out_reg.texture_barrier <= item_reg.is_texture;
                out_reg.stage_before    <= cur.stage;
                out_reg.stage_after     <= sa_reg;
                out_reg.access_before   <= cur.access;
                out_reg.access_after    <= aa_reg;
                out_reg.layout_before   <= lb;
                out_reg.layout_after    <= la_eff;
                out_reg.last            <= 1'b1;
            end
            S_FLUSH:
            begin
                if (out_free && restore)
                begin
                    out_reg.status <= (rdata.initial_layout == 4'd0) ?
                                      rbt_pkg::ST_UNDEF : rbt_pkg::ST_BARRIER;
                    out_reg.barrier_key     <= rdata.key;
                    out_reg.texture_barrier <= 1'b1;
                    out_reg.stage_before    <= rdata.stage;
                    out_reg.stage_after     <= 3'd0;
                    out_reg.access_before   <= rdata.access;
                    out_reg.access_after    <= 3'd0;
                    out_reg.layout_before   <= rdata.layout;
                    out_reg.layout_after    <= rdata.initial_layout;
                    out_reg.last            <= 1'b0;
                end
            end
            S_FEND:
            begin
                if (!out_valid_reg)
                begin
                    out_reg <= frame_res;
                end
            end
            default: ;
        endcase
    end
endmodule

[rtl/rbt_checker.sv]
// Port-level checker for the resource barrier tracker, bound to the top level.
// Depends on rbt_pkg and resource_barrier_tracker_defines.svh.
`timescale 1ns / 1ps
`include "resource_barrier_tracker_defines.svh"
module rbt_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input rbt_pkg::in_item_t  in_data,
    input logic               out_valid,
    input logic               out_ready,
    input rbt_pkg::out_item_t out_data
);
    `RBT_ASSERT(a_out_hold, clk, rst_n,
        out_valid && !out_ready |=> out_valid && $stable(out_data),
        "output item changed while stalled")
    `RBT_ASSERT(a_no_overlap, clk, rst_n,
        in_valid && in_ready |-> !out_valid,
        "input taken while a result waits")
    `RBT_ASSERT(a_frame_last, clk, rst_n,
        out_valid && out_data.status == rbt_pkg::ST_FRAME |-> out_data.last,
        "frame end item not marked last")
    `RBT_ASSERT(a_access_next, clk, rst_n,
        in_valid && in_ready && !in_data.mode && in_data.view_valid |=> !in_ready,
        "ready held right after an access")
    `RBT_ASSERT_ALWAYS(a_reset_quiet, clk,
        !rst_n |-> !out_valid,
        "result shown during reset")
endmodule

bind resource_barrier_tracker rbt_checker u_rbt_checker (.*);
